[rtl/wfht_pkg.sv]
// ----------------------------------------------------------------------------
// wfht_pkg
// Shared types, codes and constants of the window frame hit test unit.
// ----------------------------------------------------------------------------
package wfht_pkg;

   localparam int MAX_BUTTONS_DEFAULT = 8;

   // Geometry datapath width: holds pointer minus frame width plus the
   // largest button offset without overflow.
   localparam int GEO_W = 18;
   // Button offset from the frame's right edge (border + padding + buttons).
   localparam int OFF_W = 14;
   // Signed width of the button row top and bottom.
   localparam int ROW_W = 11;
   localparam int IDX_W = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 8;

   // Part codes
   localparam logic [3:0] PART_CLIENT = 4'd0;
   localparam logic [3:0] PART_TITLE  = 4'd1;
   localparam logic [3:0] PART_BUTTON = 4'd2;
   localparam logic [3:0] PART_TOP    = 4'd3;
   localparam logic [3:0] PART_BOTTOM = 4'd4;
   localparam logic [3:0] PART_LEFT   = 4'd5;
   localparam logic [3:0] PART_RIGHT  = 4'd6;
   localparam logic [3:0] PART_TL     = 4'd7;
   localparam logic [3:0] PART_TR     = 4'd8;
   localparam logic [3:0] PART_BL     = 4'd9;
   localparam logic [3:0] PART_BR     = 4'd10;

   // Resize edge mask bits
   localparam logic [3:0] EDGE_NONE   = 4'b0000;
   localparam logic [3:0] EDGE_TOP    = 4'b0001;
   localparam logic [3:0] EDGE_BOTTOM = 4'b0010;
   localparam logic [3:0] EDGE_LEFT   = 4'b0100;
   localparam logic [3:0] EDGE_RIGHT  = 4'b1000;

   localparam logic signed [IDX_W-1:0] NO_BUTTON = -4'sd1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BORDER_SIZE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TITLEBAR_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CORNER_SIZE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_SIZE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_GAP      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TITLE_PADDING   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_COUNT    = 3'd6;

   // Register reset values
   localparam logic [7:0] RST_BORDER_SIZE     = 8'd1;
   localparam logic [7:0] RST_TITLEBAR_HEIGHT = 8'd20;
   localparam logic [7:0] RST_CORNER_SIZE     = 8'd16;
   localparam logic [7:0] RST_BUTTON_SIZE     = 8'd16;
   localparam logic [7:0] RST_BUTTON_GAP      = 8'd2;
   localparam logic [7:0] RST_TITLE_PADDING   = 8'd4;
   localparam logic [3:0] RST_BUTTON_COUNT    = 4'd0;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic [14:0]        outer_width;
      logic [14:0]        outer_height;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]              part_code;
      logic signed [IDX_W-1:0] button_index;
      logic [3:0]              resize_edges;
   } rsp_payload_type;

   // Frame geometry handed from the register block to the classifier
   typedef struct packed {
      logic [7:0]              border_size;
      logic [7:0]              titlebar_height;
      logic [7:0]              corner_size;
      logic [7:0]              button_size;
      logic signed [ROW_W-1:0] row_top;
      logic signed [ROW_W-1:0] row_bottom;
   } geom_type;

   function automatic logic [3:0] edges_of_part(input logic [3:0] part);
      logic [3:0] edges;
      case (part)
         PART_TOP:    edges = EDGE_TOP;
         PART_BOTTOM: edges = EDGE_BOTTOM;
         PART_LEFT:   edges = EDGE_LEFT;
         PART_RIGHT:  edges = EDGE_RIGHT;
         PART_TL:     edges = EDGE_TOP | EDGE_LEFT;
         PART_TR:     edges = EDGE_TOP | EDGE_RIGHT;
         PART_BL:     edges = EDGE_BOTTOM | EDGE_LEFT;
         PART_BR:     edges = EDGE_BOTTOM | EDGE_RIGHT;
         default:     edges = EDGE_NONE;
      endcase
      return edges;
   endfunction

endpackage

[rtl/wfht_csr.sv]
// ----------------------------------------------------------------------------
// wfht_csr
// Configuration registers and the button geometry derived from them.
// ----------------------------------------------------------------------------
module wfht_csr
   import wfht_pkg::*;
#(
   parameter int MAX_BUTTONS = MAX_BUTTONS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output geom_type               geom,
   output logic [OFF_W-1:0]       lane_off [MAX_BUTTONS],
   output logic [MAX_BUTTONS-1:0] lane_en,
   output logic                   settle
);

   logic [7:0] border_ff, title_ff, corner_ff, bsize_ff, gap_ff, pad_ff;
   logic [3:0] count_ff;
   logic       settle_ff;

   // first derived stage
   logic [8:0]              step_ff, step_in;
   logic [9:0]              base_ff, base_in;
   logic [3:0]              n_ff, n_in;
   logic signed [ROW_W-1:0] row_top_ff, row_top_in;
   logic signed [ROW_W-1:0] row_bot_ff, row_bot_in;
   logic signed [8:0]       diff_s;
   logic signed [8:0]       half_s;

   // second derived stage, one entry per button lane
   logic [OFF_W-1:0]       lane_off_ff [MAX_BUTTONS];
   logic [MAX_BUTTONS-1:0] lane_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         border_ff <= RST_BORDER_SIZE;
         title_ff  <= RST_TITLEBAR_HEIGHT;
         corner_ff <= RST_CORNER_SIZE;
         bsize_ff  <= RST_BUTTON_SIZE;
         gap_ff    <= RST_BUTTON_GAP;
         pad_ff    <= RST_TITLE_PADDING;
         count_ff  <= RST_BUTTON_COUNT;
         settle_ff <= 1'b1;
      end else begin
         settle_ff <= csr_valid;
         if (csr_valid) begin
            case (csr_index)
               CSR_BORDER_SIZE:     border_ff <= csr_data;
               CSR_TITLEBAR_HEIGHT: title_ff  <= csr_data;
               CSR_CORNER_SIZE:     corner_ff <= csr_data;
               CSR_BUTTON_SIZE:     bsize_ff  <= csr_data;
               CSR_BUTTON_GAP:      gap_ff    <= csr_data;
               CSR_TITLE_PADDING:   pad_ff    <= csr_data;
               CSR_BUTTON_COUNT:    count_ff  <= csr_data[3:0];
               default: ;
            endcase
         end
      end
   end

   // Row offset (t - bs) / 2, rounded toward zero
   always_comb begin
      diff_s = $signed({1'b0, title_ff}) - $signed({1'b0, bsize_ff});
      half_s = (diff_s + $signed({8'd0, diff_s[8]})) >>> 1;
      step_in    = 9'(bsize_ff) + 9'(gap_ff);
      base_in    = 10'(border_ff) + 10'(pad_ff) + 10'(bsize_ff);
      n_in       = (int'(count_ff) > MAX_BUTTONS) ? 4'(MAX_BUTTONS) : count_ff;
      row_top_in = $signed({3'd0, border_ff}) + ROW_W'(half_s);
      row_bot_in = row_top_in + $signed({3'd0, bsize_ff});
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      base_ff    <= base_in;
      n_ff       <= n_in;
      row_top_ff <= row_top_in;
      row_bot_ff <= row_bot_in;
   end

   // Lane i starts (base + (n-1-i)*step) pixels left of the frame's right edge
   for (genvar i = 0; i < MAX_BUTTONS; i++) begin : g_lane
      logic [3:0]       rank;
      logic [OFF_W-1:0] lane_off_in;
      assign rank        = n_ff - 4'd1 - 4'(i);
      assign lane_off_in = OFF_W'(base_ff) + OFF_W'(rank) * OFF_W'(step_ff);

      always_ff @(posedge clock) begin
         lane_off_ff[i] <= lane_off_in;
         lane_en_ff[i]  <= (i < int'(n_ff));
      end

      assign lane_off[i] = lane_off_ff[i];
   end

   assign lane_en = lane_en_ff;
   assign settle  = settle_ff;

   assign geom.border_size     = border_ff;
   assign geom.titlebar_height = title_ff;
   assign geom.corner_size     = corner_ff;
   assign geom.button_size     = bsize_ff;
   assign geom.row_top         = row_top_ff;
   assign geom.row_bottom      = row_bot_ff;

endmodule

[rtl/wfht_classify.sv]
// ----------------------------------------------------------------------------
// wfht_classify
// Priority classification of one pointer position against the frame.
// ----------------------------------------------------------------------------
module wfht_classify
   import wfht_pkg::*;
#(
   parameter int MAX_BUTTONS = MAX_BUTTONS_DEFAULT
) (
   input  req_payload_type        req,
   input  geom_type               geom,
   input  logic [OFF_W-1:0]       lane_off [MAX_BUTTONS],
   input  logic [MAX_BUTTONS-1:0] lane_en,
   output rsp_payload_type        rsp
);

   logic signed [GEO_W-1:0] px, py, w, h, b, c, t, bs, rel;
   logic signed [GEO_W-1:0] row_top, row_bot;
   logic                    near_l, near_r, near_t, near_b;
   logic                    title_on, in_title, in_row;
   logic [MAX_BUTTONS-1:0]  hit;
   logic                    btn_found;
   logic [IDX_W-1:0]        btn_idx;
   logic [3:0]              part;
   logic signed [IDX_W-1:0] idx;

   always_comb begin
      px      = GEO_W'(req.point_x);
      py      = GEO_W'(req.point_y);
      w       = GEO_W'(req.outer_width);
      h       = GEO_W'(req.outer_height);
      b       = GEO_W'(geom.border_size);
      c       = GEO_W'(geom.corner_size);
      t       = GEO_W'(geom.titlebar_height);
      bs      = GEO_W'(geom.button_size);
      row_top = GEO_W'(geom.row_top);
      row_bot = GEO_W'(geom.row_bottom);
      rel     = px - w;

      near_l = px < c;
      near_r = px >= w - c;
      near_t = py < c;
      near_b = py >= h - c;

      title_on = geom.titlebar_height != 8'd0;
      in_title = (px >= b) && (px < w - b) && (py >= b) && (py < b + t);
      in_row   = (py >= row_top) && (py < row_bot);
   end

   for (genvar i = 0; i < MAX_BUTTONS; i++) begin : g_hit
      logic signed [GEO_W-1:0] pos;
      assign pos    = rel + GEO_W'(lane_off[i]);
      assign hit[i] = lane_en[i] && in_row && (pos >= 0) && (pos < bs);
   end

   // leftmost hit wins where buttons overlap
   always_comb begin
      btn_found = 1'b0;
      btn_idx   = '0;
      for (int i = 0; i < MAX_BUTTONS; i++) begin
         if (hit[i] && !btn_found) begin
            btn_found = 1'b1;
            btn_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      part = PART_CLIENT;
      idx  = NO_BUTTON;
      if (near_t && near_l) begin
         part = PART_TL;
      end else if (near_t && near_r) begin
         part = PART_TR;
      end else if (near_b && near_l) begin
         part = PART_BL;
      end else if (near_b && near_r) begin
         part = PART_BR;
      end else if (title_on && btn_found) begin
         part = PART_BUTTON;
         idx  = $signed(btn_idx);
      end else if (title_on && in_title) begin
         part = PART_TITLE;
      end else if (py < b) begin
         part = PART_TOP;
      end else if (py >= h - b) begin
         part = PART_BOTTOM;
      end else if (px < b) begin
         part = PART_LEFT;
      end else if (px >= w - b) begin
         part = PART_RIGHT;
      end
   end

   assign rsp.part_code    = part;
   assign rsp.button_index = idx;
   assign rsp.resize_edges = edges_of_part(part);

endmodule

[rtl/window_frame_hit_test_unit.sv]
// ----------------------------------------------------------------------------
// window_frame_hit_test_unit
// Classifies a pointer position into one part of a decorated window frame.
// ----------------------------------------------------------------------------
// One point per cycle unless a write, reset or rsp_stall holds req off: a req
// beat is captured in an input register, classified by one pass of compare
// logic (all button lanes side by side) and registered in the rsp register.
// The rate is set by that single registered pass; a stalled rsp beat holds
// while one more req beat waits in the input register. A write holds req off
// in its cycle and the cycle after it (reset too) while the per-button offsets
// are recomputed in a two-stage pipe inside the register block. csr_ready is
// always high; writes to an index past the last register are dropped.
// ----------------------------------------------------------------------------
module window_frame_hit_test_unit
   import wfht_pkg::*;
#(
   parameter int MAX_BUTTONS = MAX_BUTTONS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // pointer beats in
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   // classification beats out
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   geom_type               geom;
   logic [OFF_W-1:0]       lane_off [MAX_BUTTONS];
   logic [MAX_BUTTONS-1:0] lane_en;
   logic                   settle;

   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_req_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type cls_rsp;

   logic out_load;   // rsp register free to take a new beat
   logic s1_take;    // input register moves into rsp register
   logic req_take;   // req beat accepted this cycle

   wfht_csr #(
      .MAX_BUTTONS (MAX_BUTTONS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom),
      .lane_off  (lane_off),
      .lane_en   (lane_en),
      .settle    (settle)
   );

   wfht_classify #(
      .MAX_BUTTONS (MAX_BUTTONS)
   ) u_classify (
      .req      (s1_req_ff),
      .geom     (geom),
      .lane_off (lane_off),
      .lane_en  (lane_en),
      .rsp      (cls_rsp)
   );

   // Two-deep pipe; each register advances when the one after it frees up.
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign s1_take   = s1_valid_ff && out_load;
   // hold off req during reset, on a write, while derived geometry settles and while the pipe is full
   assign req_stall = reset || csr_valid || settle || (s1_valid_ff && !out_load);
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_load);
   assign rsp_valid_in = out_load ? s1_valid_ff : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         s1_req_ff <= req_payload;
      end
      if (s1_take) begin
         rsp_payload_ff <= cls_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready   = 1'b1;

endmodule

[rtl/wfht_checker.sv]
// ----------------------------------------------------------------------------
// wfht_checker
// Port-level checks of the hit test unit, bound to the top level.
// ----------------------------------------------------------------------------
module wfht_checker
   import wfht_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input req_payload_type        req_payload,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rsp_payload_type        rsp_payload,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   // a stalled req beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("req beat changed while stalled");

   // a stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   // no req beat is taken in the cycle after a register write
   a_csr_settle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> req_stall)
      else $error("req taken while geometry settles");

   // only a button part carries a button index
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.part_code != PART_BUTTON)
      |-> rsp_payload.button_index == NO_BUTTON)
      else $error("button index on a non-button part");

   // part code is in range and the edge mask agrees with it
   a_edges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.part_code <= PART_BR) &&
         (rsp_payload.resize_edges == edges_of_part(rsp_payload.part_code)))
      else $error("resize edges disagree with part code");

endmodule

bind window_frame_hit_test_unit wfht_checker u_checker (.*);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for window_frame_hit_test_unit. A queue of pointer
// beats feeds a clocked driver. Each accepted beat is classified by a
// behavioral frame model that runs beside the unit, and the expected
// classification is queued. A clocked monitor pops that queue for every
// rsp beat and compares it field by field. The run steps through a series
// of frame geometries, the extremes among them. Both sides idle in random
// bursts, and one long rsp hold-off backs the unit up into req.
// ----------------------------------------------------------------------------
module tb_top;
   import wfht_pkg::*;

   localparam int BUTTON_LANES = MAX_BUTTONS_DEFAULT;
   // csr index past the last register: the unit must drop the write
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int RANDOM_PER_SETTING = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   // Shadow copy of the frame geometry registers, updated on each csr beat.
   logic [7:0] geo_border   = RST_BORDER_SIZE;
   logic [7:0] geo_titlebar = RST_TITLEBAR_HEIGHT;
   logic [7:0] geo_corner   = RST_CORNER_SIZE;
   logic [7:0] geo_button   = RST_BUTTON_SIZE;
   logic [7:0] geo_gap      = RST_BUTTON_GAP;
   logic [7:0] geo_padding  = RST_TITLE_PADDING;
   logic [3:0] geo_count    = RST_BUTTON_COUNT;

   req_payload_type point_q[$];      // beats waiting to be offered
   rsp_payload_type hit_expect_q[$]; // classifications owed by the unit

   int  points_sent   = 0;
   int  hits_checked  = 0;
   int  mismatches    = 0;
   int  settings_run  = 0;
   int  part_seen[11];
   int  idle_left     = 0;  // sender gap cycles still to go
   int  stall_left    = 0;  // receiver stall cycles still to go
   logic calm         = 1'b0; // no idling in the closing stretch
   logic rsp_hold     = 1'b0; // long hold-off from the pressure process

   window_frame_hit_test_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Frame model: classify one point against the shadow geometry.
   // Priority: corners, buttons, titlebar, borders, client.
   // --------------------------------------------------------------------------
   function automatic rsp_payload_type classify_point(input req_payload_type p);
      int px, py, w, h, b, t, c, bs, gap, pad, n, row, bx, by, hit;
      logic near_l, near_r, near_t, near_b;
      logic [3:0] part;
      rsp_payload_type r;
      px  = int'($signed(p.point_x));
      py  = int'($signed(p.point_y));
      w   = int'(p.outer_width);
      h   = int'(p.outer_height);
      b   = int'(geo_border);
      t   = int'(geo_titlebar);
      c   = int'(geo_corner);
      bs  = int'(geo_button);
      gap = int'(geo_gap);
      pad = int'(geo_padding);
      // counts past the lane count clamp to the lane count
      n   = (int'(geo_count) > BUTTON_LANES) ? BUTTON_LANES : int'(geo_count);
      hit = -1;
      near_l = px < c;
      near_r = px >= w - c;
      near_t = py < c;
      near_b = py >= h - c;
      if (near_t && near_l) begin
         part = PART_TL;
      end else if (near_t && near_r) begin
         part = PART_TR;
      end else if (near_b && near_l) begin
         part = PART_BL;
      end else if (near_b && near_r) begin
         part = PART_BR;
      end else begin
         if (t > 0) begin
            // vertical centering truncates toward zero, also when negative
            by  = b + (t - bs) / 2;
            row = n * bs + ((n > 0) ? (n - 1) * gap : 0);
            bx  = w - b - pad - row;
            for (int i = 0; i < n; i++) begin
               if (hit < 0 && px >= bx && px < bx + bs && py >= by && py < by + bs)
                  hit = i;
               bx += bs + gap;
            end
         end
         if (hit >= 0)
            part = PART_BUTTON;
         else if (t > 0 && px >= b && px < w - b && py >= b && py < b + t)
            part = PART_TITLE;
         else if (py < b)
            part = PART_TOP;
         else if (py >= h - b)
            part = PART_BOTTOM;
         else if (px < b)
            part = PART_LEFT;
         else if (px >= w - b)
            part = PART_RIGHT;
         else
            part = PART_CLIENT;
      end
      r.part_code    = part;
      r.button_index = (hit < 0) ? NO_BUTTON : hit[IDX_W-1:0];
      case (part)
         PART_TOP:    r.resize_edges = EDGE_TOP;
         PART_BOTTOM: r.resize_edges = EDGE_BOTTOM;
         PART_LEFT:   r.resize_edges = EDGE_LEFT;
         PART_RIGHT:  r.resize_edges = EDGE_RIGHT;
         PART_TL:     r.resize_edges = EDGE_TOP | EDGE_LEFT;
         PART_TR:     r.resize_edges = EDGE_TOP | EDGE_RIGHT;
         PART_BL:     r.resize_edges = EDGE_BOTTOM | EDGE_LEFT;
         PART_BR:     r.resize_edges = EDGE_BOTTOM | EDGE_RIGHT;
         default:     r.resize_edges = EDGE_NONE;
      endcase
      return r;
   endfunction

   // Random coordinate within +/- spread of ctr, wrapped to 16 bits.
   function automatic logic [15:0] near(input int ctr, input int spread);
      int v;
      v = ctr - spread + int'($urandom_range(2 * spread));
      return v[15:0];
   endfunction

   function automatic req_payload_type make_point(input int x, input int y,
                                                  input int w, input int h);
      req_payload_type p;
      p.point_x      = x[15:0];
      p.point_y      = y[15:0];
      p.outer_width  = w[14:0];
      p.outer_height = h[14:0];
      return p;
   endfunction

   // Append one beat to the tail of the pending queue.
   task automatic enqueue_point(input req_payload_type p);
      point_q = {point_q, p};
   endtask

   // Random point aimed at the features of the current geometry: corners,
   // borders, the button row and the titlebar, plus some fully random beats
   // so that every payload bit toggles.
   function automatic req_payload_type random_point();
      int w, h, b, t, bs, n, row, bx, by, reach, pick;
      req_payload_type p;
      b     = int'(geo_border);
      t     = int'(geo_titlebar);
      bs    = int'(geo_button);
      reach = int'(geo_corner) + b + 4;
      n     = (int'(geo_count) > BUTTON_LANES) ? BUTTON_LANES : int'(geo_count);
      w     = ($urandom_range(9) == 0) ? int'($urandom_range(32767)) : int'($urandom_range(640));
      h     = ($urandom_range(9) == 0) ? int'($urandom_range(32767)) : int'($urandom_range(480));
      p.outer_width  = w[14:0];
      p.outer_height = h[14:0];
      pick  = int'($urandom_range(99));
      if (pick < 10) begin
         p.point_x      = 16'($urandom);
         p.point_y      = 16'($urandom);
         p.outer_width  = 15'($urandom);
         p.outer_height = 15'($urandom);
      end else if (pick < 30) begin
         // corner zones
         p.point_x = $urandom_range(1) ? near(0, reach) : near(w, reach);
         p.point_y = $urandom_range(1) ? near(0, reach) : near(h, reach);
      end else if (pick < 45) begin
         // one border, the other axis anywhere along the frame
         if ($urandom_range(1)) begin
            p.point_x = $urandom_range(1) ? near(0, reach) : near(w, reach);
            p.point_y = near(h / 2, h / 2 + 2);
         end else begin
            p.point_x = near(w / 2, w / 2 + 2);
            p.point_y = $urandom_range(1) ? near(0, reach) : near(h, reach);
         end
      end else if (pick < 75) begin
         // button row, with a little slack around it
         row = n * bs + ((n > 0) ? (n - 1) * int'(geo_gap) : 0);
         bx  = w - b - int'(geo_padding) - row;
         by  = b + (t - bs) / 2;
         p.point_x = near(bx + row / 2, row / 2 + 3);
         p.point_y = near(by + bs / 2, bs / 2 + 3);
      end else if (pick < 88) begin
         p.point_x = near(w / 2, w / 2 + 4);
         p.point_y = near(b + t / 2, t / 2 + 3);
      end else begin
         p.point_x = near(w / 2, w / 2 + 20);
         p.point_y = near(h / 2, h / 2 + 20);
      end
      return p;
   endfunction

   // --------------------------------------------------------------------------
   // Register writes. Only issued while the unit is drained.
   // --------------------------------------------------------------------------
   task automatic write_geometry_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BORDER_SIZE:     geo_border   = val;
         CSR_TITLEBAR_HEIGHT: geo_titlebar = val;
         CSR_CORNER_SIZE:     geo_corner   = val;
         CSR_BUTTON_SIZE:     geo_button   = val;
         CSR_BUTTON_GAP:      geo_gap      = val;
         CSR_TITLE_PADDING:   geo_padding  = val;
         CSR_BUTTON_COUNT:    geo_count    = val[3:0];
         default: ;
      endcase
   endtask

   task automatic load_geometry(input logic [7:0] b, input logic [7:0] t,
                                input logic [7:0] c, input logic [7:0] bs,
                                input logic [7:0] gap, input logic [7:0] pad,
                                input logic [7:0] cnt);
      write_geometry_reg(CSR_BORDER_SIZE, b);
      write_geometry_reg(CSR_TITLEBAR_HEIGHT, t);
      write_geometry_reg(CSR_CORNER_SIZE, c);
      write_geometry_reg(CSR_BUTTON_SIZE, bs);
      write_geometry_reg(CSR_BUTTON_GAP, gap);
      write_geometry_reg(CSR_TITLE_PADDING, pad);
      write_geometry_reg(CSR_BUTTON_COUNT, cnt);
   endtask

   // Wait until every queued beat went in and every classification came out,
   // then let the two-stage pipe settle.
   task automatic drain_unit();
      while (point_q.size() != 0 || req_valid || hit_expect_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // Driver: offers queued points, predicts each accepted beat.
   // A gap is only started once the current beat has gone in.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            hit_expect_q = {hit_expect_q, classify_point(req_payload)};
            points_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(5) == 0) begin
               idle_left = int'($urandom_range(4));
               req_valid <= 1'b0;
            end else if (point_q.size() != 0) begin
               req_valid   <= 1'b1;
               req_payload <= point_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: checks every rsp beat against the oldest prediction and drives
   // the receiver's stall (random bursts plus the long hold-off).
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_payload_type want;
      logic burst;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (hit_expect_q.size() == 0) begin
               $error("rsp beat with no classification pending: part_code %0d",
                      rsp_payload.part_code);
               mismatches++;
            end else begin
               want = hit_expect_q.pop_front();
               if (rsp_payload.part_code !== want.part_code) begin
                  $error("part_code: expected %0d, got %0d",
                         want.part_code, rsp_payload.part_code);
                  mismatches++;
               end
               if (rsp_payload.button_index !== want.button_index) begin
                  $error("button_index: expected %0d, got %0d",
                         want.button_index, rsp_payload.button_index);
                  mismatches++;
               end
               if (rsp_payload.resize_edges !== want.resize_edges) begin
                  $error("resize_edges: expected %b, got %b",
                         want.resize_edges, rsp_payload.resize_edges);
                  mismatches++;
               end
               hits_checked++;
               if (want.part_code <= PART_BR)
                  part_seen[want.part_code]++;
            end
         end
         burst = 1'b0;
         if (stall_left > 0) begin
            stall_left--;
            burst = 1'b1;
         end else if (!calm && $urandom_range(6) == 0) begin
            stall_left = int'($urandom_range(4));
            burst = 1'b1;
         end
         rsp_stall <= burst || rsp_hold;
      end
   end

   // Back-pressure: once the run is well into the first programmed geometry,
   // hold rsp off long enough that the unit fills and stalls req.
   initial begin
      while (points_sent < 150) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (60) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Run limit, far past the slowest legal run.
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < 11; i++) part_seen[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry as it comes out of reset.
      repeat (50) enqueue_point(random_point());
      drain_unit();
      settings_run++;

      for (int setting = 0; setting < 8; setting++) begin
         case (setting)
            // three buttons, comfortable frame; directed points follow
            0: load_geometry(8'd4, 8'd24, 8'd10, 8'd16, 8'd3, 8'd5, 8'd3);
            // everything zero: no titlebar, no corners, no borders
            1: load_geometry(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
            // everything at its top; count 15 clamps to the lane count
            2: load_geometry(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F);
            // full button row, buttons touching, flush to the right end
            3: load_geometry(8'd2, 8'd30, 8'd8, 8'd12, 8'd0, 8'd0, 8'd8);
            // buttons taller than the titlebar: odd negative centering offset;
            // upper data bits of the count must be ignored
            4: load_geometry(8'd1, 8'd11, 8'd6, 8'd30, 8'd0, 8'd2, 8'hF4);
            // corners reach past the titlebar, count 9 clamps
            5: load_geometry(8'd3, 8'd20, 8'd40, 8'd16, 8'd2, 8'd4, 8'd9);
            default: begin
               load_geometry(8'($urandom_range(12)), 8'($urandom_range(48)),
                             8'($urandom_range(24)), 8'($urandom_range(1, 40)),
                             8'($urandom_range(6)), 8'($urandom_range(10)),
                             8'($urandom_range(255)));
               // dropped write: the geometry must not move
               write_geometry_reg(CSR_UNUSED_INDEX, 8'($urandom_range(255)));
            end
         endcase
         settings_run++;

         if (setting == 0) begin
            // Frame 200x100: buttons at x [137,153) [156,172) [175,191),
            // y [8,24); titlebar x [4,196), y [4,28).
            enqueue_point(make_point(0, 0, 200, 100));         // TL
            enqueue_point(make_point(199, 0, 200, 100));       // TR
            enqueue_point(make_point(0, 99, 200, 100));        // BL
            enqueue_point(make_point(199, 99, 200, 100));      // BR
            enqueue_point(make_point(-32768, -32768, 200, 100));
            enqueue_point(make_point(32767, 32767, 200, 100));
            enqueue_point(make_point(-5, 50, 200, 100));       // grab margin
            enqueue_point(make_point(137, 8, 200, 100));       // first button
            enqueue_point(make_point(152, 23, 200, 100));      // its far corner
            enqueue_point(make_point(153, 8, 200, 100));       // gap: titlebar
            enqueue_point(make_point(156, 8, 200, 100));
            enqueue_point(make_point(190, 23, 200, 100));      // last button
            enqueue_point(make_point(191, 8, 200, 100));       // padding
            enqueue_point(make_point(50, 10, 200, 100));       // titlebar
            enqueue_point(make_point(50, 3, 200, 100));        // top border
            enqueue_point(make_point(50, 28, 200, 100));       // client
            enqueue_point(make_point(50, 96, 200, 100));       // bottom
            enqueue_point(make_point(2, 50, 200, 100));        // left
            enqueue_point(make_point(196, 50, 200, 100));      // right
            enqueue_point(make_point(195, 50, 200, 100));      // client edge
            // frame too small for its own borders and corners
            enqueue_point(make_point(5, 5, 0, 0));
            enqueue_point(make_point(20, 20, 0, 0));
            enqueue_point(make_point(20, 5, 0, 0));
            // largest frame
            enqueue_point(make_point(32767, -32768, 32767, 32767));
            enqueue_point(make_point(-32768, 32767, 32767, 32767));
         end

         // closing stretch runs without any idling
         if (setting == 7) calm <= 1'b1;
         repeat (RANDOM_PER_SETTING) enqueue_point(random_point());
         drain_unit();
      end

      // give any stray rsp beat time to show up
      repeat (10) @(posedge clock);
      $display("Classified %0d points over %0d frame geometries (incl. reset).",
               hits_checked, settings_run);
      $display("Hits: %0d button, %0d titlebar, %0d corner, %0d client, %0d border.",
               part_seen[PART_BUTTON], part_seen[PART_TITLE],
               part_seen[PART_TL] + part_seen[PART_TR] + part_seen[PART_BL]
                  + part_seen[PART_BR],
               part_seen[PART_CLIENT],
               part_seen[PART_TOP] + part_seen[PART_BOTTOM] + part_seen[PART_LEFT]
                  + part_seen[PART_RIGHT]);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
rtl/wfht_pkg.sv
rtl/wfht_csr.sv
rtl/wfht_classify.sv
rtl/window_frame_hit_test_unit.sv
rtl/wfht_checker.sv
test/tb_top.sv
